// ----- rtl/core/ssui_pkg.sv -----
// shared constants for the sorted set union / intersection engine
// list capacity, index widths, item kind codes and register indexes; no dependencies
package ssui_pkg;

   localparam int MAX_ELEMENTS = 32;
   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   localparam int DATA_W     = 32;
   localparam int LEN_W      = 6;
   localparam int REG_IDX_W  = 1;
   localparam int ADDR_W     = REG_IDX_W + 2;

   // item kinds
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_RUN    = 2'd2;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_MODE   = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_LENGTH = 1'b1;

   // mode register values
   localparam logic MODE_UNION     = 1'b0;
   localparam logic MODE_INTERSECT = 1'b1;

endpackage

// ----- rtl/core/sorted_set_union_intersection.sv -----
// sorted set union / intersection engine: two list memories and a merge sequencer
// depends on ssui_pkg
//
//   channel   direction   transfer
//   req       in          one item: kind and value (load A, load B or run)
//   rsp       out         one result: value, valid flag, last flag
//   csr       in/out      register write or read over an APB-style port
//
// loads are taken while the sequencer is idle; a run makes up to 2*n merge steps
// for n = min(list_length, MAX_ELEMENTS), plus the start in S_IDLE, one closing step
// and the final result in S_DONE. each merge step is the registered read of the list
// memories (S_FETCH) followed by the shared signed compares (S_STEP).
// reset clears the fill counts, registers and sequencer; list contents are kept.
// a stalled result only holds the sequencer; req_stall stays high for the whole run.

module sorted_set_union_intersection (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic signed [ssui_pkg::DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ssui_pkg::DATA_W-1:0] rsp_result_value,
   output logic                          rsp_result_valid,
   output logic                          rsp_result_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ssui_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import ssui_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_STEP  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic [CNT_W-1:0] a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   logic signed [DATA_W-1:0] pend_ff, pend_in;
   logic pend_vld_ff, pend_vld_in;
   logic mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic out_vld_ff, out_vld_in;
   logic signed [DATA_W-1:0] out_val_ff, out_val_in;
   logic out_rv_ff, out_rv_in, out_last_ff, out_last_in;

   logic signed [DATA_W-1:0] mem_a [MAX_ELEMENTS];
   logic signed [DATA_W-1:0] mem_b [MAX_ELEMENTS];
   logic signed [DATA_W-1:0] a_rd_ff, b_rd_ff;

   logic req_xfer, wr_a, wr_b, csr_wr;
   logic [REG_IDX_W-1:0] csr_idx;
   logic out_free, a_ok, b_ok, a_lt_b, b_lt_a, take_a;
   logic signed [DATA_W-1:0] pick;

   assign pready    = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign wr_a = req_xfer && (req_kind == KIND_LOAD_A) && (a_cnt_ff < CNT_W'(MAX_ELEMENTS));
   assign wr_b = req_xfer && (req_kind == KIND_LOAD_B) && (b_cnt_ff < CNT_W'(MAX_ELEMENTS));

   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[ADDR_W-1:2];

   always_comb begin
      prdata = '0;
      case (csr_idx)
         REG_MODE:   prdata[0]         = mode_ff;
         REG_LENGTH: prdata[LEN_W-1:0] = len_ff;
         default:    prdata            = '0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_MODE:   mode_in = pwdata[0];
            REG_LENGTH: len_in  = pwdata[LEN_W-1:0];
            default:    ;
         endcase
      end
   end

   // compare logic shared by both modes: pointer bounds and two signed compares
   assign a_ok   = (i_ff < n_ff);
   assign b_ok   = (j_ff < n_ff);
   assign a_lt_b = (a_rd_ff < b_rd_ff);
   assign b_lt_a = (b_rd_ff < a_rd_ff);
   assign take_a = a_ok && (!b_ok || !b_lt_a);
   assign pick   = take_a ? a_rd_ff : b_rd_ff;

   assign out_free = !out_vld_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      n_in        = n_ff;
      a_cnt_in    = a_cnt_ff + CNT_W'(wr_a);
      b_cnt_in    = b_cnt_ff + CNT_W'(wr_b);
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_vld_in  = out_vld_ff && rsp_stall;
      out_val_in  = out_val_ff;
      out_rv_in   = out_rv_ff;
      out_last_in = out_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_kind == KIND_RUN)) begin
               n_in        = (len_ff > LEN_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                              : CNT_W'(len_ff);
               i_in        = '0;
               j_in        = '0;
               a_cnt_in    = '0;
               b_cnt_in    = '0;
               pend_vld_in = 1'b0;
               state_in    = S_FETCH;
            end
         end
         S_FETCH: state_in = S_STEP;
         S_STEP: begin
            if (out_free) begin
               state_in = S_FETCH;
               if (mode_ff == MODE_UNION) begin
                  if (!a_ok && !b_ok) begin
                     state_in = S_DONE;
                  end else begin
                     if (take_a) i_in = i_ff + CNT_W'(1);
                     else        j_in = j_ff + CNT_W'(1);
                     // pending value is the last one kept; a new one pushes it out
                     if (!pend_vld_ff || (pick != pend_ff)) begin
                        if (pend_vld_ff) begin
                           out_vld_in  = 1'b1;
                           out_val_in  = pend_ff;
                           out_rv_in   = 1'b1;
                           out_last_in = 1'b0;
                        end
                        pend_in     = pick;
                        pend_vld_in = 1'b1;
                     end
                  end
               end else begin
                  if (!(a_ok && b_ok)) begin
                     state_in = S_DONE;
                  end else if (a_lt_b) begin
                     i_in = i_ff + CNT_W'(1);
                  end else if (b_lt_a) begin
                     j_in = j_ff + CNT_W'(1);
                  end else begin
                     i_in = i_ff + CNT_W'(1);
                     j_in = j_ff + CNT_W'(1);
                     if (pend_vld_ff) begin
                        out_vld_in  = 1'b1;
                        out_val_in  = pend_ff;
                        out_rv_in   = 1'b1;
                        out_last_in = 1'b0;
                     end
                     pend_in     = a_rd_ff;
                     pend_vld_in = 1'b1;
                  end
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               // last transfer of the run, or the empty-answer marker
               out_vld_in  = 1'b1;
               out_val_in  = pend_vld_ff ? pend_ff : '0;
               out_rv_in   = pend_vld_ff;
               out_last_in = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         a_cnt_ff    <= '0;
         b_cnt_ff    <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         mode_ff     <= MODE_UNION;
         len_ff      <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
         n_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         a_cnt_ff    <= a_cnt_in;
         b_cnt_ff    <= b_cnt_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         mode_ff     <= mode_in;
         len_ff      <= len_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         n_ff        <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_val_ff  <= out_val_in;
      out_rv_ff   <= out_rv_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_a) mem_a[a_cnt_ff[IDX_W-1:0]] <= req_value;
      a_rd_ff <= mem_a[i_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) mem_b[b_cnt_ff[IDX_W-1:0]] <= req_value;
      b_rd_ff <= mem_b[j_ff[IDX_W-1:0]];
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_result_value = out_val_ff;
   assign rsp_result_valid = out_rv_ff;
   assign rsp_result_last  = out_last_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (a_cnt_ff <= CNT_W'(MAX_ELEMENTS)) && (b_cnt_ff <= CNT_W'(MAX_ELEMENTS)))
      else $error("fill count beyond capacity");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> ((i_ff <= n_ff) && (j_ff <= n_ff)))
      else $error("merge pointer beyond list length");

   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_kind == KIND_RUN)) |=>
         ((state_ff == S_FETCH) && (a_cnt_ff == '0) && (b_cnt_ff == '0)))
      else $error("run did not start or clear fill counts");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_valid) |-> rsp_result_last)
      else $error("empty-answer result not marked last");
`endif

endmodule

// ----- verif/sorted_set_union_intersection_tb.sv -----
// self-checking testbench for the sorted set union / intersection engine
// sends loads, runs and register writes, predicts every merge result and checks it in order
// depends on ssui_pkg and the sorted_set_union_intersection top level
module sorted_set_union_intersection_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssui_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 30;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS   = 10;
   localparam int GEN_DEPTH     = 40;

   localparam logic [1:0]  KIND_UNUSED = 2'd3;
   localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
   localparam logic [31:0] VAL_MAX     = 32'h7FFF_FFFF;

   // shapes of generated list content
   localparam int STYLE_NARROW   = 0;
   localparam int STYLE_WIDE     = 1;
   localparam int STYLE_UNSORTED = 2;

   // receiver stall patterns
   localparam int STALL_NONE    = 0;
   localparam int STALL_SCATTER = 1;
   localparam int STALL_LONG    = 2;

   typedef struct packed {
      logic [31:0] value;
      logic        valid;
      logic        last;
   } merge_out_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_kind = KIND_LOAD_A;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic                     rsp_result_valid;
   logic                     rsp_result_last;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;

   sorted_set_union_intersection uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_result_valid (rsp_result_valid),
      .rsp_result_last  (rsp_result_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // shadow of the engine: list stores, fill counts, registers
   logic [31:0]     a_mem [MAX_ELEMENTS];
   logic [31:0]     b_mem [MAX_ELEMENTS];
   bit              a_seen [MAX_ELEMENTS];
   bit              b_seen [MAX_ELEMENTS];
   int              a_fill = 0;
   int              b_fill = 0;
   logic            cfg_mode = MODE_UNION;
   logic [LEN_W-1:0] cfg_len = '0;

   merge_out_type   awaited_merge_q [$];
   merge_out_type   head_result;
   logic [31:0]     gen_a [GEN_DEPTH];
   logic [31:0]     gen_b [GEN_DEPTH];

   int items_sent = 0;
   int runs_sent = 0;
   int results_seen = 0;
   int fail_count = 0;
   int burst_left = 0;
   int cycle_count = 0;
   int stall_style = STALL_NONE;
   int style_left = 0;
   int stall_run = 0;
   bit stall_high = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count++;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, awaited_merge_q.size());
      $display("Verification failed");
      $finish;
   end

   // expected results of one accepted item
   function automatic void predict_merge(logic [1:0] kind, logic [31:0] v);
      merge_out_type outs [2*MAX_ELEMENTS];
      int          n;
      int          i;
      int          j;
      int          cnt;
      logic [31:0] x;
      logic [31:0] prev;
      bit          have;
      i = 0;
      j = 0;
      cnt = 0;
      prev = '0;
      have = 1'b0;
      case (kind)
         KIND_LOAD_A: begin
            if (a_fill < MAX_ELEMENTS) begin
               a_mem[a_fill] = v;
               a_seen[a_fill] = 1'b1;
               a_fill++;
            end
            return;
         end
         KIND_LOAD_B: begin
            if (b_fill < MAX_ELEMENTS) begin
               b_mem[b_fill] = v;
               b_seen[b_fill] = 1'b1;
               b_fill++;
            end
            return;
         end
         KIND_RUN: ;
         default: return;
      endcase
      n = (cfg_len > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(cfg_len);
      if (cfg_mode == MODE_UNION) begin
         while (i < n || j < n) begin
            if (i < n && (j >= n || !($signed(b_mem[j]) < $signed(a_mem[i])))) begin
               x = a_mem[i];
               i++;
            end else begin
               x = b_mem[j];
               j++;
            end
            // drop a repeat of the value just emitted, never the first one
            if (!have || x != prev) begin
               outs[cnt] = {x, 1'b1, 1'b0};
               cnt++;
               prev = x;
               have = 1'b1;
            end
         end
      end else begin
         while (i < n && j < n) begin
            if ($signed(a_mem[i]) < $signed(b_mem[j])) begin
               i++;
            end else if ($signed(b_mem[j]) < $signed(a_mem[i])) begin
               j++;
            end else begin
               outs[cnt] = {a_mem[i], 1'b1, 1'b0};
               cnt++;
               i++;
               j++;
            end
         end
      end
      if (cnt == 0) begin
         outs[0] = {32'h0, 1'b0, 1'b0};
         cnt = 1;
      end
      outs[cnt-1].last = 1'b1;
      for (int k = 0; k < cnt; k++) awaited_merge_q = {awaited_merge_q, outs[k]};
      a_fill = 0;
      b_fill = 0;
   endfunction

   function automatic bit entries_written(bit on_b, int n);
      for (int k = 0; k < n; k++) begin
         if (on_b ? !b_seen[k] : !a_seen[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void make_list(bit to_b, int count, int style);
      longint      acc;
      logic [31:0] w;
      acc = (style == STYLE_WIDE) ? longint'($signed($urandom()))
                                  : longint'($urandom_range(0, 12)) - 6;
      for (int k = 0; k < count; k++) begin
         if (style == STYLE_UNSORTED) begin
            w = $urandom();
         end else begin
            if (acc > longint'(VAL_MAX)) acc = longint'(VAL_MAX);
            w = acc[31:0];
            acc += (style == STYLE_WIDE) ? longint'($urandom_range(0, 32'h0800_0000))
                                         : longint'($urandom_range(0, 2));
         end
         if (to_b) gen_b[k] = w;
         else gen_a[k] = w;
      end
   endfunction

   // one request transfer; valid stays high between items of a burst
   task automatic send_item(logic [1:0] kind, logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      predict_merge(kind, value);
      if (kind != KIND_UNUSED) items_sent++;
      if (kind == KIND_RUN) runs_sent++;
   endtask

   // hold the sender until every awaited result has come, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_merge_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_MODE) cfg_mode = data[0];
      else cfg_len = data[LEN_W-1:0];
      @(posedge clock);
   endtask

   task automatic set_config(logic mode, int len);
      drain_results();
      csr_write(REG_MODE, {31'b0, mode});
      csr_write(REG_LENGTH, 32'(len));
   endtask

   // loads for both lists in random order, with ignored items mixed in when broken, then a run
   task automatic merge_round(int style, bit broken);
      int eff;
      int ka;
      int kb;
      int ia;
      int ib;
      eff = (cfg_len > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(cfg_len);
      ka = eff;
      kb = eff;
      if (broken) begin
         // short loads only where every entry the run reads holds an older value
         ka = (entries_written(1'b0, eff) && $urandom_range(0, 1) == 1)
              ? $urandom_range(0, eff) : eff + $urandom_range(0, 3);
         kb = (entries_written(1'b1, eff) && $urandom_range(0, 1) == 1)
              ? $urandom_range(0, eff) : eff + $urandom_range(0, 3);
      end
      make_list(1'b0, ka, style);
      make_list(1'b1, kb, style);
      ia = 0;
      ib = 0;
      while (ia < ka || ib < kb) begin
         if (broken && $urandom_range(0, 9) == 0) send_item(KIND_UNUSED, $urandom());
         if (ia < ka && (ib >= kb || $urandom_range(0, 1) == 1)) begin
            send_item(KIND_LOAD_A, gen_a[ia]);
            ia++;
         end else begin
            send_item(KIND_LOAD_B, gen_b[ib]);
            ib++;
         end
      end
      send_item(KIND_RUN, $urandom());
   endtask

   task automatic test_union_basics();
      set_config(MODE_UNION, 3);
      send_item(KIND_LOAD_A, VAL_MIN);
      send_item(KIND_LOAD_B, -7);
      send_item(KIND_LOAD_A, 5);
      send_item(KIND_LOAD_B, 5);
      send_item(KIND_LOAD_A, 5);
      send_item(KIND_LOAD_B, VAL_MAX);
      send_item(KIND_RUN, 0);
      // a leading zero must still be emitted
      set_config(MODE_UNION, 1);
      send_item(KIND_LOAD_A, 0);
      send_item(KIND_LOAD_B, 0);
      send_item(KIND_RUN, VAL_MAX);
   endtask

   task automatic test_intersection_basics();
      set_config(MODE_INTERSECT, 3);
      send_item(KIND_LOAD_A, 0);
      send_item(KIND_LOAD_A, 0);
      send_item(KIND_LOAD_A, VAL_MAX);
      send_item(KIND_LOAD_B, 0);
      send_item(KIND_LOAD_B, 0);
      send_item(KIND_LOAD_B, VAL_MAX);
      send_item(KIND_RUN, VAL_MIN);
   endtask

   task automatic test_empty_answers();
      set_config(MODE_INTERSECT, 2);
      send_item(KIND_LOAD_A, 1);
      send_item(KIND_LOAD_B, 3);
      send_item(KIND_UNUSED, 32'hFFFF_FFFF);
      send_item(KIND_LOAD_A, 2);
      send_item(KIND_LOAD_B, 4);
      send_item(KIND_RUN, 0);
      set_config(MODE_UNION, 0);
      send_item(KIND_RUN, 0);
   endtask

   // full lists, a load into a full list, and a length above capacity
   task automatic test_full_lists();
      set_config(MODE_UNION, 40);
      make_list(1'b0, MAX_ELEMENTS + 1, STYLE_WIDE);
      make_list(1'b1, MAX_ELEMENTS, STYLE_WIDE);
      for (int k = 0; k <= MAX_ELEMENTS; k++) send_item(KIND_LOAD_A, gen_a[k]);
      for (int k = 0; k < MAX_ELEMENTS; k++) send_item(KIND_LOAD_B, gen_b[k]);
      send_item(KIND_RUN, 0);
   endtask

   task automatic test_random_merges();
      int start;
      int pick;
      int style;
      start = items_sent;
      while (items_sent < start + RANDOM_ITEMS) begin
         if (items_sent == start || $urandom_range(0, 2) == 0) begin
            set_config($urandom_range(0, 1), $urandom_range(0, 10));
         end
         pick = $urandom_range(0, 19);
         style = (pick < 10) ? STYLE_NARROW : (pick < 17) ? STYLE_WIDE : STYLE_UNSORTED;
         merge_round(style, style == STYLE_UNSORTED || $urandom_range(0, 4) == 0);
      end
   endtask

   // receiver stall patterns change every so often
   always @(posedge clock) begin
      if (style_left == 0) begin
         stall_style = $urandom_range(STALL_NONE, STALL_LONG);
         style_left = $urandom_range(20, 200);
      end
      style_left--;
      case (stall_style)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_SCATTER: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run == 0) begin
               stall_high = !stall_high;
               stall_run = stall_high ? $urandom_range(1, 12) : $urandom_range(1, 8);
            end
            stall_run--;
            rsp_stall <= stall_high;
         end
      endcase
   end

   // compare each result transfer with the oldest awaited one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_merge_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result: value %0d valid %b last %b",
                        rsp_result_value, rsp_result_valid, rsp_result_last);
         end else begin
            head_result = awaited_merge_q.pop_front();
            results_seen++;
            if (rsp_result_value !== head_result.value ||
                rsp_result_valid !== head_result.valid ||
                rsp_result_last !== head_result.last) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display({"result %0d: expected value %0d valid %b last %b, ",
                            "got value %0d valid %b last %b"},
                           results_seen, $signed(head_result.value), head_result.valid,
                           head_result.last, rsp_result_value, rsp_result_valid,
                           rsp_result_last);
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_union_basics();
      test_intersection_basics();
      test_empty_answers();
      test_full_lists();
      test_random_merges();
      drain_results();
      $display("ran %0d items with %0d runs, %0d results checked, %0d failures",
               items_sent, runs_sent, results_seen, fail_count);
      $display("union and intersection at lengths 0 to 10, full lists above capacity, %s",
               "unsorted and ignored items");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
